// ===== rtl/gmt_pkg.sv =====
// Package for the group membership table: sizes, operation and status codes,
// controller states and the controller/datapath command and status structs.
// No dependencies.
package gmt_pkg;

  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned BATCH_MAX   = 16;

  localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned BC_W  = 5;
  localparam int unsigned SUM_W = ((CNT_W > BC_W) ? CNT_W : BC_W) + 1;

  localparam int unsigned GRP_W  = 32;
  localparam int unsigned UNIT_W = 8;
  localparam int unsigned OUT_CNT_W = 7;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_MODIFY = 2'd1;
  localparam logic [1:0] OP_DELETE = 2'd2;

  localparam logic [1:0] ST_COMPLETE  = 2'd0;
  localparam logic [1:0] ST_NO_SPACE  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_SEARCH,
    S_ACT,
    S_DEL_WR,
    S_RESP
  } gmt_state_e;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic [GRP_W-1:0]  grp;
  } gmt_entry_t;

  typedef struct packed {
    logic       load_item;
    logic       upd_rej;
    logic       scan_clr;
    logic       scan_step;
    logic       wr_add;
    logic       wr_mod;
    logic       del_rd;
    logic       del_wr;
    logic       cnt_dec;
    logic       res_set;
    logic [1:0] res_status;
    logic       res_ins;
    logic       out_load;
  } gmt_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       rej_eff;
    logic       hit;
    logic       not_found;
    logic       found;
    logic       full;
    logic       slot_last;
    logic       out_free;
  } gmt_stat_t;

endpackage

// ===== rtl/group_membership_table.sv =====
// Top level of the group membership table: stream ports, field unpacking,
// controller and datapath. Depends on gmt_pkg, gmt_ctrl and gmt_dp.
//
// The block holds up to TABLE_DEPTH (group number, unit) pairs and takes one
// add, modify or delete per input beat, returning one result beat for each.
// Every operation that touches the table scans it linearly through a single
// registered-read memory port, one entry per cycle; a rejected add batch and
// an unused opcode skip the scan. A hit ends the scan early, and a delete
// that moves the last entry into the hole adds a write step. One item is
// worked on at a time; the next input beat is taken as soon as the previous
// result sits in the output register, even if the sink has not taken it yet.
// The capacity check of an add batch is made on the beat flagged
// first_of_batch; a rejected batch reports "no space" for each of its adds.
// No clearing pass runs after reset: only entries below the count are ever
// read.
module group_membership_table import gmt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] unit_id, [39:8] group_number, [71:40] new_group_number,
  // [72] first_of_batch, [77:73] batch_count, [79:78] zero
  input  logic [79:0] s_axis_tdata,
  // [1:0] opcode
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [6:0] entry_count, [7] inserted
  output logic [7:0]  m_axis_tdata,
  // [1:0] status
  output logic [1:0]  m_axis_tuser
);

  gmt_cmd_t  cmd;
  gmt_stat_t stat;

  logic [OUT_CNT_W-1:0] entry_count;
  logic                 inserted;
  logic [1:0]           status;

  gmt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  gmt_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .opcode_i           (s_axis_tuser),
    .unit_id_i          (s_axis_tdata[7:0]),
    .group_number_i     (s_axis_tdata[39:8]),
    .new_group_number_i (s_axis_tdata[71:40]),
    .first_of_batch_i   (s_axis_tdata[72]),
    .batch_count_i      (s_axis_tdata[77:73]),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .out_ready_i        (m_axis_tready),
    .out_valid_o        (m_axis_tvalid),
    .status_o           (status),
    .entry_count_o      (entry_count),
    .inserted_o         (inserted)
  );

  // result beat packing
  assign m_axis_tdata = {inserted, entry_count};
  assign m_axis_tuser = status;

endmodule

// ===== rtl/gmt_ctrl.sv =====
// Controller FSM of the group membership table.
// Depends on gmt_pkg; drives gmt_cmd_t to gmt_dp and reads gmt_stat_t back.
module gmt_ctrl import gmt_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  gmt_stat_t stat_i,
  output gmt_cmd_t  cmd_o
);

  gmt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_START;
      end
      S_START: begin
        if (stat_i.op == OP_ADD) begin
          state_d = stat_i.rej_eff ? S_RESP : S_SEARCH;
        end else if (stat_i.op == OP_MODIFY || stat_i.op == OP_DELETE) begin
          state_d = S_SEARCH;
        end else begin
          state_d = S_RESP;
        end
      end
      S_SEARCH: begin
        if (stat_i.hit || stat_i.not_found) state_d = S_ACT;
      end
      S_ACT: begin
        if (stat_i.op == OP_DELETE && stat_i.found && !stat_i.slot_last) begin
          state_d = S_DEL_WR;
        end else begin
          state_d = S_RESP;
        end
      end
      S_DEL_WR: state_d = S_RESP;
      S_RESP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.load_item = in_valid_i;
      end
      S_START: begin
        if (stat_i.op == OP_ADD) begin
          cmd_o.upd_rej = 1'b1;
          if (stat_i.rej_eff) begin
            cmd_o.res_set    = 1'b1;
            cmd_o.res_status = ST_NO_SPACE;
          end else begin
            cmd_o.scan_clr = 1'b1;
          end
        end else if (stat_i.op == OP_MODIFY || stat_i.op == OP_DELETE) begin
          cmd_o.scan_clr = 1'b1;
        end else begin
          cmd_o.res_set    = 1'b1;
          cmd_o.res_status = ST_COMPLETE;
        end
      end
      S_SEARCH: cmd_o.scan_step = 1'b1;
      S_ACT: begin
        cmd_o.res_set    = 1'b1;
        cmd_o.res_status = ST_COMPLETE;
        if (stat_i.op == OP_ADD) begin
          if (!stat_i.found) begin
            if (stat_i.full) begin
              cmd_o.res_status = ST_NO_SPACE;
            end else begin
              cmd_o.wr_add  = 1'b1;
              cmd_o.res_ins = 1'b1;
            end
          end
        end else if (stat_i.op == OP_MODIFY) begin
          if (stat_i.found) begin
            cmd_o.wr_mod = 1'b1;
          end else begin
            cmd_o.res_status = ST_NOT_FOUND;
          end
        end else if (stat_i.op == OP_DELETE) begin
          if (stat_i.found) begin
            if (stat_i.slot_last) begin
              cmd_o.cnt_dec = 1'b1;
            end else begin
              cmd_o.del_rd = 1'b1;
            end
          end
        end
      end
      S_DEL_WR: cmd_o.del_wr = 1'b1;
      S_RESP:   cmd_o.out_load = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== rtl/gmt_dp.sv =====
// Datapath of the group membership table: item register, entry memory,
// linear scan, entry count, batch reject flag and output register.
// Depends on gmt_pkg; controlled by gmt_ctrl through gmt_cmd_t.
module gmt_dp import gmt_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        opcode_i,
  input  logic [UNIT_W-1:0] unit_id_i,
  input  logic [GRP_W-1:0]  group_number_i,
  input  logic [GRP_W-1:0]  new_group_number_i,
  input  logic              first_of_batch_i,
  input  logic [BC_W-1:0]   batch_count_i,
  input  gmt_cmd_t          cmd_i,
  output gmt_stat_t         stat_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [1:0]        status_o,
  output logic [OUT_CNT_W-1:0] entry_count_o,
  output logic              inserted_o
);

  // latched item
  logic [1:0]        op_q;
  logic [UNIT_W-1:0] unit_q;
  logic [GRP_W-1:0]  grp_q;
  logic [GRP_W-1:0]  new_grp_q;
  logic              first_q;
  logic [BC_W-1:0]   bc_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q      <= opcode_i;
      unit_q    <= unit_id_i;
      grp_q     <= group_number_i;
      new_grp_q <= new_group_number_i;
      first_q   <= first_of_batch_i;
      bc_q      <= batch_count_i;
    end
  end

  // control state
  logic [CNT_W-1:0] count_q, count_d;
  logic             rej_q;
  logic [CNT_W-1:0] scan_q;
  logic             pend_q;
  logic [IDX_W-1:0] cmp_idx_q;
  logic             found_q;
  logic [IDX_W-1:0] slot_q;

  logic             issue;
  logic             hit;
  logic             rej_new;
  logic [CNT_W-1:0] count_m1;
  logic [IDX_W-1:0] last_idx;
  logic [SUM_W-1:0] need;

  gmt_entry_t       mem [TABLE_DEPTH];
  gmt_entry_t       rd_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  gmt_entry_t       wr_data;

  assign count_m1 = count_q - CNT_W'(1);
  assign last_idx = count_m1[IDX_W-1:0];
  assign need     = SUM_W'(count_q) + SUM_W'(bc_q);
  assign rej_new  = need > SUM_W'(TABLE_DEPTH);
  assign issue    = cmd_i.scan_step && (scan_q < count_q);
  assign hit      = pend_q && (rd_q.grp == grp_q) && (rd_q.unit == unit_q);

  // memory ports: one read, one write
  assign rd_en   = issue || cmd_i.del_rd;
  assign rd_addr = cmd_i.del_rd ? last_idx : scan_q[IDX_W-1:0];
  assign wr_en   = cmd_i.wr_add || cmd_i.wr_mod || cmd_i.del_wr;

  always_comb begin
    wr_addr = slot_q;
    wr_data = rd_q;
    if (cmd_i.wr_add) begin
      wr_addr = count_q[IDX_W-1:0];
      wr_data = '{unit: unit_q, grp: grp_q};
    end else if (cmd_i.wr_mod) begin
      wr_data = '{unit: unit_q, grp: new_grp_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_comb begin
    count_d = count_q;
    if (cmd_i.wr_add) begin
      count_d = count_q + CNT_W'(1);
    end else if (cmd_i.del_wr || cmd_i.cnt_dec) begin
      count_d = count_m1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      rej_q     <= 1'b0;
      scan_q    <= '0;
      pend_q    <= 1'b0;
      cmp_idx_q <= '0;
      found_q   <= 1'b0;
      slot_q    <= '0;
    end else begin
      count_q <= count_d;
      if (cmd_i.upd_rej && first_q) rej_q <= rej_new;
      if (cmd_i.scan_clr) begin
        scan_q  <= '0;
        pend_q  <= 1'b0;
        found_q <= 1'b0;
      end else if (cmd_i.scan_step) begin
        pend_q    <= issue;
        cmp_idx_q <= scan_q[IDX_W-1:0];
        if (issue) scan_q <= scan_q + CNT_W'(1);
        if (hit) begin
          found_q <= 1'b1;
          slot_q  <= cmp_idx_q;
        end
      end
    end
  end

  // result and output register
  logic [1:0]             res_status_q;
  logic                   res_ins_q;
  logic                   out_valid_q;
  logic [1:0]             out_status_q;
  logic [OUT_CNT_W-1:0]   out_cnt_q;
  logic                   out_ins_q;
  logic [CNT_W+OUT_CNT_W-1:0] count_ext;

  assign count_ext = {{OUT_CNT_W{1'b0}}, count_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_set) begin
      res_status_q <= cmd_i.res_status;
      res_ins_q    <= cmd_i.res_ins;
    end
    if (cmd_i.out_load) begin
      out_status_q <= res_status_q;
      out_ins_q    <= res_ins_q;
      out_cnt_q    <= count_ext[OUT_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_count_o = out_cnt_q;
  assign inserted_o    = out_ins_q;

  always_comb begin
    stat_o           = '0;
    stat_o.op        = op_q;
    stat_o.rej_eff   = first_q ? rej_new : rej_q;
    stat_o.hit       = hit;
    stat_o.not_found = !pend_q && (scan_q == count_q);
    stat_o.found     = found_q;
    stat_o.full      = count_q == CNT_W'(TABLE_DEPTH);
    stat_o.slot_last = CNT_W'(slot_q) == count_m1;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

endmodule

// ===== tb/tb_top.sv =====
// Testbench for group_membership_table: directed and random add, modify and
// delete beats, checked against an in-bench table predictor.
// Depends on gmt_pkg and the group_membership_table RTL.
module tb_top;
  import gmt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned HOLD_OFF_CYCLES = 400;
  localparam int unsigned STALL_LIMIT = 3000;
  localparam int unsigned RANDOM_ITEMS = 285;

  typedef struct packed {
    logic [1:0] status;
    logic [6:0] count;
    logic       inserted;
  } table_reply_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  // shadow copy of the table
  logic [GRP_W-1:0]  shadow_grp[TABLE_DEPTH];
  logic [UNIT_W-1:0] shadow_unit[TABLE_DEPTH];
  int                shadow_count = 0;
  logic              shadow_rejected = 1'b0;

  table_reply_t predicted_replies[$];
  int           mismatch_cnt = 0;
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_off_req = 0;
  int           hold_off_taken = 0;
  int           hold_left = 0;
  int           quiet_cycles = 0;
  bit           draining = 1'b0;

  group_membership_table DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic int find_slot(logic [GRP_W-1:0] grp, logic [UNIT_W-1:0] unit);
    for (int k = 0; k < shadow_count; k++) begin
      if (shadow_grp[k] == grp && shadow_unit[k] == unit) return k;
    end
    return -1;
  endfunction

  // Applies one entry operation to the shadow table, returns the reply beat.
  function automatic table_reply_t apply_entry_op(logic [1:0] op, logic [UNIT_W-1:0] unit,
                                                  logic [GRP_W-1:0] grp,
                                                  logic [GRP_W-1:0] new_grp,
                                                  logic first, logic [4:0] bcount);
    table_reply_t r;
    int slot;
    int last_idx;
    r.status   = ST_COMPLETE;
    r.inserted = 1'b0;
    slot = find_slot(grp, unit);
    case (op)
      OP_ADD: begin
        if (first) shadow_rejected = (shadow_count + int'(bcount) > TABLE_DEPTH);
        if (shadow_rejected) begin
          r.status = ST_NO_SPACE;
        end else if (slot < 0) begin
          if (shadow_count < TABLE_DEPTH) begin
            shadow_grp[shadow_count]  = grp;
            shadow_unit[shadow_count] = unit;
            shadow_count++;
            r.inserted = 1'b1;
          end else begin
            r.status = ST_NO_SPACE;
          end
        end
      end
      OP_MODIFY: begin
        if (slot < 0) r.status = ST_NOT_FOUND;
        else shadow_grp[slot] = new_grp;
      end
      OP_DELETE: begin
        if (slot >= 0) begin
          // last entry fills the hole
          last_idx = shadow_count - 1;
          shadow_grp[slot]  = shadow_grp[last_idx];
          shadow_unit[slot] = shadow_unit[last_idx];
          shadow_count = last_idx;
        end
      end
      default: ;
    endcase
    r.count = shadow_count[6:0];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_cnt++;
    // keep the log short if the block loses step
    if (mismatch_cnt <= 100) $display("MISMATCH at %0t ns: %s", $realtime, msg);
  endtask

  // One input beat. tvalid stays high after acceptance unless a gap follows,
  // so back-to-back beats never see a low/high pair in one step.
  task automatic send_entry_op(input logic [1:0] op, input logic [UNIT_W-1:0] unit,
                               input logic [GRP_W-1:0] grp, input logic [GRP_W-1:0] new_grp,
                               input logic first, input logic [4:0] bcount);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, bcount, first, new_grp, grp, unit};
    s_axis_tuser  <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted_replies.push_back(apply_entry_op(op, unit, grp, new_grp, first, bcount));
    if (shadow_count >= TABLE_DEPTH - 2) draining = 1'b1;
    else if (shadow_count <= 6) draining = 1'b0;
  endtask

  // Mostly a small pool so duplicates and hits are common; sometimes full range.
  task automatic pick_pair(output logic [UNIT_W-1:0] unit, output logic [GRP_W-1:0] grp);
    unit = ($urandom_range(0, 3) == 0) ? UNIT_W'($urandom_range(0, 255))
                                       : UNIT_W'($urandom_range(0, 7));
    grp  = ($urandom_range(0, 3) == 0) ? $urandom() : GRP_W'($urandom_range(0, 15));
  endtask

  // Either an existing pair (if any) or a fresh pick.
  task automatic pick_target(input int hit_pct, output logic [UNIT_W-1:0] unit,
                             output logic [GRP_W-1:0] grp);
    int idx;
    if (shadow_count > 0 && $urandom_range(0, 99) < hit_pct) begin
      idx  = $urandom_range(0, shadow_count - 1);
      unit = shadow_unit[idx];
      grp  = shadow_grp[idx];
    end else begin
      pick_pair(unit, grp);
    end
  endtask

  task automatic send_random_add(input logic first, input logic [4:0] bcount);
    logic [UNIT_W-1:0] unit;
    logic [GRP_W-1:0]  grp;
    pick_target(20, unit, grp);
    send_entry_op(OP_ADD, unit, grp, $urandom(), first, bcount);
  endtask

  task automatic send_random_lookup(input logic [1:0] op);
    logic [UNIT_W-1:0] unit;
    logic [GRP_W-1:0]  grp;
    logic [GRP_W-1:0]  new_grp;
    pick_target(70, unit, grp);
    new_grp = $urandom_range(0, 1) ? $urandom() : GRP_W'($urandom_range(0, 15));
    send_entry_op(op, unit, grp, new_grp, 1'($urandom_range(0, 1)),
                  5'($urandom_range(0, 31)));
  endtask

  // Random mix; sends about n_items beats that touch the table.
  task automatic run_random_mix(input int n_items);
    int sent;
    int r;
    int bsize;
    logic [4:0] bcount;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      // filling favors add batches, draining favors deletes
      if (r < (draining ? 25 : 55)) begin
        bsize  = ($urandom_range(0, 7) == 0) ? BATCH_MAX : $urandom_range(1, 6);
        // the declared size is usually honest; otherwise anything the field allows
        bcount = ($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31)) : 5'(bsize);
        for (int k = 0; k < bsize; k++) send_random_add(k == 0, bcount);
        sent += bsize;
      end else if (r < (draining ? 40 : 70)) begin
        send_random_lookup(OP_MODIFY);
        sent++;
      end else if (r < (draining ? 90 : 85)) begin
        send_random_lookup(OP_DELETE);
        sent++;
      end else if (r < 95) begin
        // stray add outside a batch start
        send_random_add(1'b0, 5'($urandom_range(0, 31)));
        sent++;
      end else begin
        send_random_lookup(OP_UNUSED);
      end
    end
  endtask

  task automatic test_directed_entry_ops();
    send_entry_op(OP_ADD, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b1, 5'd0);
    send_entry_op(OP_ADD, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 5'd0);
    send_entry_op(OP_ADD, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd31);
    send_entry_op(OP_ADD, 8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 5'd0);
    send_entry_op(OP_MODIFY, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 5'd0);
    send_entry_op(OP_MODIFY, 8'hFF, 32'h0000_0000, 32'hFFFF_FFFF, 1'b1, 5'd31);
    send_entry_op(OP_MODIFY, 8'h5A, 32'hA5A5_A5A5, 32'h1234_5678, 1'b0, 5'd1);
    send_entry_op(OP_DELETE, 8'h5A, 32'hA5A5_A5A5, 32'h0000_0000, 1'b0, 5'd16);
    send_entry_op(OP_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 5'd31);
    send_entry_op(OP_DELETE, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 5'd0);
    send_entry_op(OP_DELETE, 8'hFF, 32'h0000_0000, 32'h0000_0000, 1'b0, 5'd0);
    send_entry_op(OP_DELETE, 8'hFF, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, 5'd0);
    send_entry_op(OP_MODIFY, 8'h00, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 5'd0);
    send_entry_op(OP_DELETE, 8'h00, 32'h0000_0000, 32'h0000_0000, 1'b0, 5'd0);
  endtask

  // Sink holds off while the source keeps offering beats.
  task automatic test_output_backpressure();
    hold_off_req++;
    for (int k = 0; k < 20; k++) send_random_lookup(k[0] ? OP_DELETE : OP_MODIFY);
  endtask

  task automatic test_random_phases();
    send_idle_pct = 0;  recv_stall_pct = 0;  run_random_mix(RANDOM_ITEMS);
    send_idle_pct = 55; recv_stall_pct = 0;  run_random_mix(RANDOM_ITEMS);
    send_idle_pct = 0;  recv_stall_pct = 55; run_random_mix(RANDOM_ITEMS);
    send_idle_pct = 17; recv_stall_pct = 17; run_random_mix(RANDOM_ITEMS);
  endtask

  // sink side: random stalls plus the long hold-off on request
  always @(posedge clk_i) begin
    if (hold_off_req != hold_off_taken) begin
      hold_off_taken <= hold_off_req;
      hold_left      <= HOLD_OFF_CYCLES;
      m_axis_tready  <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // result checker
  always @(posedge clk_i) begin
    table_reply_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (predicted_replies.size() == 0) begin
        report_mismatch($sformatf("reply beat with none pending (status %0d count %0d)",
                                  m_axis_tuser, m_axis_tdata[6:0]));
      end else begin
        want = predicted_replies.pop_front();
        if (m_axis_tuser !== want.status)
          report_mismatch($sformatf("status got %0d want %0d", m_axis_tuser, want.status));
        if (m_axis_tdata[6:0] !== want.count)
          report_mismatch($sformatf("entry_count got %0d want %0d",
                                    m_axis_tdata[6:0], want.count));
        if (m_axis_tdata[7] !== want.inserted)
          report_mismatch($sformatf("inserted got %0b want %0b",
                                    m_axis_tdata[7], want.inserted));
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_entry_ops();
    test_output_backpressure();
    test_random_phases();
    s_axis_tvalid <= 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    while (predicted_replies.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
